// ----- sv/ffsa_pkg.sv -----
`timescale 1ns / 1ps

package ffsa_pkg;

  // Default values for the top-level parameters.
  localparam int TABLE_SIDE_DEF  = 32;
  localparam int SECTOR_SIZE_DEF = 4096;
  localparam int MAX_SECTORS_DEF = 4096;
  localparam int MAX_RUN_DEF     = 255;

  // The start field is 12 bits wide, so the map never reaches past 4096 sectors.
  localparam int SEC_LIMIT_CAP = 4096;

  // Field widths.
  localparam int OP_W     = 2;
  localparam int CHUNK_W  = 5;
  localparam int START_W  = 12;
  localparam int COUNT_W  = 8;
  localparam int BYTES_W  = 20;
  localparam int STATUS_W = 3;
  localparam int ENTRY_W  = START_W + COUNT_W;

  // A byte count plus the length prefix fits in one more bit than the byte count.
  localparam int SIZE_W = BYTES_W + 1;
  localparam int LEN_PREFIX = 4;

  // Sector arithmetic holds a 12-bit start plus an 8-bit offset.
  localparam int SUM_W = 13;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD   = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_ALLOC  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  // Sector map codes.
  localparam logic [1:0] SEC_ABSENT = 2'd0;
  localparam logic [1:0] SEC_FREE   = 2'd1;
  localparam logic [1:0] SEC_TAKEN  = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STAT_IN_PLACE = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_MOVED    = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_TOO_BIG  = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_NO_SPACE = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_ABSENT   = 3'd4;
  localparam logic [STATUS_W-1:0] STAT_FOUND    = 3'd5;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_ENTRY,
    ST_SIZE,
    ST_MARK,
    ST_SCAN_START,
    ST_SCAN
  } state_t;

  typedef struct packed {
    op_t                  operation;
    logic [CHUNK_W-1:0]   chunk_x;
    logic [CHUNK_W-1:0]   chunk_z;
    logic [START_W-1:0]   load_start;
    logic [COUNT_W-1:0]   load_count;
    logic [BYTES_W-1:0]   payload_bytes;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [START_W-1:0]   start_sector;
    logic [COUNT_W-1:0]   sector_count;
    logic                 header_update;
  } res_t;

  typedef struct packed {
    logic                 fin;
    logic                 too_big;
    logic [COUNT_W-1:0]   need;
  } size_res_t;

  function automatic res_t make_res(logic [STATUS_W-1:0] st, logic [START_W-1:0] s,
                                    logic [COUNT_W-1:0] c, logic upd);
    res_t r;
    r.status        = st;
    r.start_sector  = s;
    r.sector_count  = c;
    r.header_update = upd;
    return r;
  endfunction

endpackage

// ----- sv/ffsa_ram.sv -----
`timescale 1ns / 1ps

module ffsa_ram #(
  parameter int W = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/ffsa_sizer.sv -----
`timescale 1ns / 1ps

// Sector count of a payload by repeated subtraction of the sector size.
// Stops early once the count can no longer fit in a run.
module ffsa_sizer import ffsa_pkg::*; #(
  parameter int SECTOR_SIZE = SECTOR_SIZE_DEF,
  parameter int MAX_RUN = MAX_RUN_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               go,
  input  logic [BYTES_W-1:0] bytes,
  output size_res_t          res
);

  localparam logic [SIZE_W-1:0]  SS     = SIZE_W'(SECTOR_SIZE);
  localparam logic [COUNT_W-1:0] Q_LAST = COUNT_W'(MAX_RUN - 1);

  logic               running, running_next;
  logic [SIZE_W-1:0]  rem, rem_next;
  logic [COUNT_W-1:0] q, q_next;
  logic               below;

  always_comb begin
    below        = rem < SS;
    res.fin      = running && (below || q == Q_LAST);
    res.too_big  = !below;
    res.need     = q + 1'b1;
    running_next = running;
    rem_next     = rem;
    q_next       = q;
    if (go) begin
      running_next = 1'b1;
      rem_next     = SIZE_W'(bytes) + SIZE_W'(LEN_PREFIX);
      q_next       = '0;
    end else if (res.fin) begin
      running_next = 1'b0;
    end else if (running) begin
      rem_next = rem - SS;
      q_next   = q + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
    end else begin
      running <= running_next;
    end
    rem <= rem_next;
    q   <= q_next;
  end

endmodule

// ----- sv/first_fit_sector_allocator.sv -----
`timescale 1ns / 1ps

// Channel   Handshake            Payload         Direction
// command   start, busy          cmd (cmd_t)     in
// result    done (strobe)        result (res_t)  out
//
// After reset a clearing pass writes both memories with busy high. A lookup reads the table
// entry, and a load writes it and marks its run taken. An allocate sizes the payload and,
// unless it is too big or fits in place, frees the old run, scans the map for a first fit
// and marks the new run.
// The strobe lasts one cycle and cannot be held off; busy is low again in that same cycle.

module first_fit_sector_allocator import ffsa_pkg::*; #(
  parameter int TABLE_SIDE  = TABLE_SIDE_DEF,
  parameter int SECTOR_SIZE = SECTOR_SIZE_DEF,
  parameter int MAX_SECTORS = MAX_SECTORS_DEF,
  parameter int MAX_RUN     = MAX_RUN_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  cmd_t cmd,
  output logic busy,
  output logic done,
  output res_t result
);

  localparam int CELLS        = TABLE_SIDE * TABLE_SIDE;
  localparam int SECTOR_LIMIT = (MAX_SECTORS < SEC_LIMIT_CAP) ? MAX_SECTORS : SEC_LIMIT_CAP;
  localparam int TAB_AW       = $clog2(CELLS);
  localparam int MAP_AW       = $clog2(SECTOR_LIMIT);
  localparam int CLR_N        = (CELLS > SECTOR_LIMIT) ? CELLS : SECTOR_LIMIT;
  localparam int CLR_W        = $clog2(CLR_N);
  localparam logic [SUM_W-1:0] LIM = SUM_W'(SECTOR_LIMIT);

  // Control state.
  state_t             state, state_next;
  logic [CLR_W-1:0]   clr, clr_next;
  logic               done_next;

  // Transaction context.
  cmd_t               op, op_next;
  logic [TAB_AW-1:0]  idx, idx_next;
  logic [START_W-1:0] old_start, old_start_next;
  logic [COUNT_W-1:0] old_cnt, old_cnt_next;
  logic [COUNT_W-1:0] need, need_next;
  res_t               result_next;

  // Run marker: writes one sector per cycle from mk_base on.
  logic [SUM_W-1:0]   mk_base, mk_base_next;
  logic [COUNT_W-1:0] mk_cnt, mk_cnt_next;
  logic [COUNT_W-1:0] mk_i, mk_i_next;
  logic [1:0]         mk_val, mk_val_next;
  state_t             mk_ret, mk_ret_next;
  res_t               res_pend, res_pend_next;
  logic [SUM_W-1:0]   mk_sum;

  // First-fit scan. The position always advances by one, so the map read for
  // the next position is issued while the current one is evaluated.
  logic [SUM_W-1:0]   p, p_next;
  logic [SUM_W-1:0]   slot, slot_next;
  logic [COUNT_W-1:0] run, run_next;
  logic [SUM_W-1:0]   p_inc;
  logic               go_take, go_restore;

  // Memory ports.
  logic               tab_we;
  logic [TAB_AW-1:0]  tab_waddr;
  logic [ENTRY_W-1:0] tab_wdata;
  logic [ENTRY_W-1:0] tab_rd;
  logic [TAB_AW-1:0]  idx_in;
  logic               map_we;
  logic [MAP_AW-1:0]  map_waddr;
  logic [1:0]         map_wdata;
  logic [MAP_AW-1:0]  map_raddr;
  logic [1:0]         map_rd;

  logic               sz_go;
  size_res_t          sz;

  // Chunk coordinates folded into the table side.
  logic [CHUNK_W-1:0] side_mod [2**CHUNK_W];

  always_comb begin
    for (int i = 0; i < 2**CHUNK_W; i++) begin
      side_mod[i] = CHUNK_W'(i % TABLE_SIDE);
    end
  end

  assign idx_in = TAB_AW'(32'(side_mod[cmd.chunk_z]) * TABLE_SIDE
                          + 32'(side_mod[cmd.chunk_x]));

  assign mk_sum = mk_base + SUM_W'(mk_i);
  assign p_inc  = p + 1'b1;
  assign busy   = (state != ST_IDLE);

  ffsa_ram #(.W(ENTRY_W), .DEPTH(CELLS)) u_table (
    .clk   (clk),
    .we    (tab_we),
    .waddr (tab_waddr),
    .wdata (tab_wdata),
    .raddr (idx_in),
    .rdata (tab_rd)
  );

  ffsa_ram #(.W(2), .DEPTH(SECTOR_LIMIT)) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (map_raddr),
    .rdata (map_rd)
  );

  ffsa_sizer #(.SECTOR_SIZE(SECTOR_SIZE), .MAX_RUN(MAX_RUN)) u_sizer (
    .clk   (clk),
    .rst   (rst),
    .go    (sz_go),
    .bytes (op.payload_bytes),
    .res   (sz)
  );

  always_comb begin
    state_next     = state;
    clr_next       = clr;
    done_next      = 1'b0;
    op_next        = op;
    idx_next       = idx;
    old_start_next = old_start;
    old_cnt_next   = old_cnt;
    need_next      = need;
    result_next    = result;
    mk_base_next   = mk_base;
    mk_cnt_next    = mk_cnt;
    mk_i_next      = mk_i;
    mk_val_next    = mk_val;
    mk_ret_next    = mk_ret;
    res_pend_next  = res_pend;
    p_next         = p;
    slot_next      = slot;
    run_next       = run;
    go_take        = 1'b0;
    go_restore     = 1'b0;
    tab_we         = 1'b0;
    tab_waddr      = idx;
    tab_wdata      = '0;
    map_we         = 1'b0;
    map_waddr      = mk_sum[MAP_AW-1:0];
    map_wdata      = mk_val;
    map_raddr      = '0;
    sz_go          = 1'b0;

    unique case (state)
      ST_INIT: begin
        // Clearing pass: empty table, sector 0 taken, all other sectors absent.
        tab_we    = {1'b0, clr} < (CLR_W + 1)'(CELLS);
        tab_waddr = clr[TAB_AW-1:0];
        map_we    = {1'b0, clr} < (CLR_W + 1)'(SECTOR_LIMIT);
        map_waddr = clr[MAP_AW-1:0];
        map_wdata = (clr == '0) ? SEC_TAKEN : SEC_ABSENT;
        clr_next  = clr + 1'b1;
        if (clr == CLR_W'(CLR_N - 1)) begin
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (start) begin
          op_next    = cmd;
          idx_next   = idx_in;
          state_next = ST_ENTRY;
        end
      end

      ST_ENTRY: begin
        // The table entry read at the accept edge is valid in this cycle only.
        old_start_next = tab_rd[ENTRY_W-1:COUNT_W];
        old_cnt_next   = tab_rd[COUNT_W-1:0];
        unique case (op.operation)
          OP_LOAD: begin
            tab_we = 1'b1;
            if (op.load_count == '0) begin
              tab_wdata   = '0;
              done_next   = 1'b1;
              result_next = make_res(STAT_FOUND, '0, '0, 1'b0);
              state_next  = ST_IDLE;
            end else begin
              tab_wdata     = {op.load_start, op.load_count};
              mk_base_next  = SUM_W'(op.load_start);
              mk_cnt_next   = op.load_count;
              mk_i_next     = '0;
              mk_val_next   = SEC_TAKEN;
              mk_ret_next   = ST_IDLE;
              res_pend_next = make_res(STAT_FOUND, op.load_start, op.load_count, 1'b0);
              state_next    = ST_MARK;
            end
          end
          OP_LOOKUP: begin
            done_next  = 1'b1;
            state_next = ST_IDLE;
            if (tab_rd == '0) begin
              result_next = make_res(STAT_ABSENT, '0, '0, 1'b0);
            end else begin
              result_next = make_res(STAT_FOUND, tab_rd[ENTRY_W-1:COUNT_W],
                                     tab_rd[COUNT_W-1:0], 1'b0);
            end
          end
          OP_ALLOC: begin
            sz_go      = 1'b1;
            state_next = ST_SIZE;
          end
          OP_NONE: begin
            state_next = ST_IDLE;
          end
        endcase
      end

      ST_SIZE: begin
        if (sz.fin) begin
          if (sz.too_big) begin
            done_next   = 1'b1;
            result_next = make_res(STAT_TOO_BIG, '0, '0, 1'b0);
            state_next  = ST_IDLE;
          end else if (old_start != '0 && old_cnt == sz.need) begin
            done_next   = 1'b1;
            result_next = make_res(STAT_IN_PLACE, old_start, old_cnt, 1'b0);
            state_next  = ST_IDLE;
          end else begin
            // Release the old run before searching.
            need_next    = sz.need;
            mk_base_next = SUM_W'(old_start);
            mk_cnt_next  = old_cnt;
            mk_i_next    = '0;
            mk_val_next  = SEC_FREE;
            mk_ret_next  = ST_SCAN_START;
            state_next   = ST_MARK;
          end
        end
      end

      ST_MARK: begin
        if (mk_i == mk_cnt || mk_sum >= LIM) begin
          state_next = mk_ret;
          if (mk_ret == ST_IDLE) begin
            done_next   = 1'b1;
            result_next = res_pend;
          end
        end else begin
          // The header sector is never released.
          map_we    = !(mk_sum == '0 && mk_val != SEC_TAKEN);
          mk_i_next = mk_i + 1'b1;
        end
      end

      ST_SCAN_START: begin
        map_raddr  = '0;
        p_next     = '0;
        slot_next  = '0;
        run_next   = '0;
        state_next = ST_SCAN;
      end

      ST_SCAN: begin
        map_raddr = p_inc[MAP_AW-1:0];
        if (run >= need) begin
          go_take = 1'b1;
        end else if (p >= LIM) begin
          go_restore = 1'b1;
        end else if (map_rd == SEC_ABSENT) begin
          // The store grows at the current slot if the run still fits.
          if (slot + SUM_W'(need) <= LIM) begin
            go_take = 1'b1;
          end else begin
            go_restore = 1'b1;
          end
        end else if (map_rd == SEC_FREE) begin
          run_next = run + 1'b1;
          p_next   = p_inc;
        end else begin
          slot_next = p_inc;
          run_next  = '0;
          p_next    = p_inc;
        end

        if (go_take) begin
          tab_we        = 1'b1;
          tab_wdata     = {slot[START_W-1:0], need};
          mk_base_next  = slot;
          mk_cnt_next   = need;
          mk_i_next     = '0;
          mk_val_next   = SEC_TAKEN;
          mk_ret_next   = ST_IDLE;
          res_pend_next = make_res(STAT_MOVED, slot[START_W-1:0], need, 1'b1);
          state_next    = ST_MARK;
        end
        if (go_restore) begin
          // No room: take the old run back and leave the table as it was.
          mk_base_next  = SUM_W'(old_start);
          mk_cnt_next   = old_cnt;
          mk_i_next     = '0;
          mk_val_next   = SEC_TAKEN;
          mk_ret_next   = ST_IDLE;
          res_pend_next = make_res(STAT_NO_SPACE, '0, '0, 1'b0);
          state_next    = ST_MARK;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
      clr   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      clr   <= clr_next;
      done  <= done_next;
    end
    op        <= op_next;
    idx       <= idx_next;
    old_start <= old_start_next;
    old_cnt   <= old_cnt_next;
    need      <= need_next;
    result    <= result_next;
    mk_base   <= mk_base_next;
    mk_cnt    <= mk_cnt_next;
    mk_i      <= mk_i_next;
    mk_val    <= mk_val_next;
    mk_ret    <= mk_ret_next;
    res_pend  <= res_pend_next;
    p         <= p_next;
    slot      <= slot_next;
    run       <= run_next;
  end

endmodule
